// ----- rtl/core/bdae_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdae_pkg: shared definitions for the binary to decimal ASCII emitter
// Widths, digit counts and character constants used by the converter core
// and by the top level.
// ----------------------------------------------------------------------------
package bdae_pkg;

  // Width of the number input port.
  localparam int FIELD_BITS = 32;

  // Width of the number that is converted; bits above it are ignored.
  localparam int VALUE_BITS = 32;

  // Bits that actually take part in the conversion.
  localparam int CONV_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

  // Decimal digits needed for CONV_BITS bits (1233/4096 approximates log10(2)).
  localparam int DIGITS = ((CONV_BITS * 1233) >> 12) + 1;

  // Index width for the digit store and width of the shift counter.
  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W = (CONV_BITS > 1) ? $clog2(CONV_BITS) : 1;

  // Output character width and the code of the character '0'.
  localparam int CHAR_W     = 6;
  localparam int ASCII_ZERO = 48;

  typedef logic [3:0] digit_t;

endpackage
`default_nettype wire

// ----- rtl/core/bdae_dabble.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdae_dabble: shift-and-add-3 binary to BCD converter
// Shifts the binary number into a BCD digit store one bit per cycle, with
// the add-3 correction applied to every digit before each shift.
// ----------------------------------------------------------------------------
module bdae_dabble (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                load,
  input  wire logic [bdae_pkg::FIELD_BITS-1:0]     value,
  output logic                                     done,
  output bdae_pkg::digit_t                         digits [bdae_pkg::DIGITS]
);

  logic [bdae_pkg::CONV_BITS-1:0] shift_reg;
  logic [bdae_pkg::CNT_W-1:0]     cnt;
  logic                           running;
  bdae_pkg::digit_t               corr [bdae_pkg::DIGITS];
  bdae_pkg::digit_t               digits_next [bdae_pkg::DIGITS];

  // Add 3 to every digit of 5 or more, then shift the whole store left by
  // one bit, taking in the top bit of the binary shift register.
  always_comb begin
    for (int i = 0; i < bdae_pkg::DIGITS; i++) begin
      corr[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
    digits_next[0] = {corr[0][2:0], shift_reg[bdae_pkg::CONV_BITS-1]};
    for (int i = 1; i < bdae_pkg::DIGITS; i++) begin
      digits_next[i] = {corr[i][2:0], corr[i-1][3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running   <= 1'b1;
        cnt       <= '0;
        shift_reg <= value[bdae_pkg::CONV_BITS-1:0];
        for (int i = 0; i < bdae_pkg::DIGITS; i++) begin
          digits[i] <= '0;
        end
      end else if (running) begin
        digits    <= digits_next;
        shift_reg <= shift_reg << 1;
        cnt       <= cnt + 1'b1;
        if (cnt == bdae_pkg::CNT_W'(bdae_pkg::CONV_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/binary_to_decimal_ascii_emitter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_emitter_top: unsigned number to decimal ASCII digits
// Converts one unsigned number into its decimal digits and emits them as
// ASCII characters, most significant first, with no leading zeros.
// ----------------------------------------------------------------------------
// An item is accepted on a rising edge with start high and busy low. The
// number is then converted by a shift-and-add-3 (double dabble) unit that
// takes one input bit per cycle. When it is done, the leading digit is
// located and its index registered, and the first digit is then registered
// onto the outputs. The digits then leave
// at one per cycle, each on digit_char for exactly one cycle with strobe
// high; the receiver cannot stall them and must take every one. The least
// significant digit carries last_digit. A zero input gives the single
// character '0'. An item gives 1 to 10 digits. busy is high while it is
// converted and emitted, except in the cycle of the final strobe.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_emitter_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [bdae_pkg::FIELD_BITS-1:0]     number_value,
  output logic                                     busy,
  output logic                                     strobe,
  output logic [bdae_pkg::CHAR_W-1:0]              digit_char,
  output logic                                     last_digit
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_EMIT
  } state_t;

  state_t                    state;
  logic                      load;
  logic                      conv_done;
  bdae_pkg::digit_t          digits [bdae_pkg::DIGITS];
  logic [bdae_pkg::IDX_W-1:0] lead;
  logic [bdae_pkg::IDX_W-1:0] idx;

  assign busy = (state != S_IDLE);
  assign load = start && !busy;

  bdae_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .value  (number_value),
    .done   (conv_done),
    .digits (digits)
  );

  // Position of the most significant nonzero digit. A zero value leaves it
  // at the units digit, which produces the single character '0'.
  always_comb begin
    lead = '0;
    for (int i = 1; i < bdae_pkg::DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        lead = bdae_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      idx    <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (load) begin
            state <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          if (conv_done) begin
            idx   <= lead;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe     <= 1'b1;
          digit_char <= bdae_pkg::CHAR_W'(bdae_pkg::ASCII_ZERO) +
                        {{(bdae_pkg::CHAR_W-4){1'b0}}, digits[idx]};
          last_digit <= (idx == '0);
          if (idx == '0) begin
            state <= S_IDLE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item keeps the block busy on the following cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    load |=> busy)
    else $error("accepted item did not make the block busy");

  // Only the final digit of a run may appear while the block is idle.
  a_mid_digit_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_digit) |-> busy)
    else $error("digit emitted outside of a conversion");

  // The final digit ends the run: no strobe follows it directly.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_digit) |=> !strobe)
    else $error("digit emitted after the last digit");

  // Every emitted character is a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (digit_char >= 6'd48 && digit_char <= 6'd57))
    else $error("emitted character is not a decimal digit");

endmodule
`default_nettype wire

// ----- dv/tb_binary_to_decimal_ascii_emitter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_emitter_top: self-checking bench for the emitter
// Feeds unsigned numbers into the converter with random idle gaps, works out
// the decimal ASCII digits that each number must produce, and compares every
// strobed character and end mark against them in order.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_emitter_top;

  import bdae_pkg::*;

  // A 32-bit number never has more than ten decimal digits, and the digit
  // store of the block holds no more than that either.
  localparam int MAX_DIGITS = 10;

  // Only the low CONV_BITS bits of a number take part in the conversion.
  localparam logic [63:0] CONV_MASK =
    (CONV_BITS >= 64) ? {64{1'b1}} : ((64'd1 << CONV_BITS) - 64'd1);

  // One number waiting to be sent, with the idle cycles that precede it and
  // a flag that makes the sender wait until all earlier digits are out.
  typedef struct {
    logic [FIELD_BITS-1:0] value;
    int unsigned           gap;
    bit                    drain;
  } number_item_t;

  // One character that the block must emit.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_char_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [FIELD_BITS-1:0] number_value = '0;
  logic                  busy;
  logic                  strobe;
  logic [CHAR_W-1:0]     digit_char;
  logic                  last_digit;

  number_item_t pending_numbers[$];
  digit_char_t  expected_chars[$];
  digit_char_t  want_char;

  // The driver counts items it has put on the port, the monitor counts the
  // ones the block has taken. While they differ an item is still on offer.
  int unsigned issued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned idle_count     = 0;
  int unsigned mismatch_count = 0;

  binary_to_decimal_ascii_emitter_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .number_value (number_value),
    .busy         (busy),
    .strobe       (strobe),
    .digit_char   (digit_char),
    .last_digit   (last_digit)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Works out the characters for one accepted number and appends them to the
  // expected stream. The digits come out of repeated division by ten, least
  // significant first, and are then emitted in the opposite order. A zero
  // still gives one digit, because the loop always runs at least once.
  function automatic void predict_digits(input logic [FIELD_BITS-1:0] raw);
    logic [63:0] remaining;
    digit_t      digits [MAX_DIGITS];
    int          n;
    digit_char_t c;
    remaining = {{(64-FIELD_BITS){1'b0}}, raw} & CONV_MASK;
    n = 0;
    while (n == 0 || remaining != 64'd0) begin
      if (n < MAX_DIGITS) begin
        digits[n] = digit_t'(remaining % 64'd10);
        n++;
      end
      remaining = remaining / 64'd10;
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.ch   = CHAR_W'(ASCII_ZERO + int'(digits[k]));
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  task automatic queue_number(input logic [FIELD_BITS-1:0] value,
                              input int unsigned gap, input bit drain);
    number_item_t item;
    item.value = value;
    item.gap   = gap;
    item.drain = drain;
    pending_numbers.push_back(item);
  endtask

  // Only the first few mismatches are printed so that a broken block does
  // not flood the log; all of them count toward the verdict.
  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // Driver. It works on the falling edge so that start and number_value are
  // stable well before the rising edge at which the block samples them. An
  // item stays on the port until the monitor has seen it taken; only then
  // does the driver count down the gap of the next item, or wait for the
  // output to drain when that item asks for it.
  always @(negedge clk) begin
    if (!rst && issued_count == accepted_count) begin
      if (pending_numbers.size() == 0) begin
        start <= 1'b0;
      end else if (idle_count < pending_numbers[0].gap) begin
        idle_count++;
        start <= 1'b0;
      end else if (pending_numbers[0].drain && expected_chars.size() != 0) begin
        start <= 1'b0;
      end else begin
        number_value <= pending_numbers[0].value;
        start        <= 1'b1;
        void'(pending_numbers.pop_front());
        idle_count = 0;
        issued_count++;
      end
    end
  end

  // Monitor. On every rising edge it first checks a strobed character against
  // the oldest expectation, then records a number taken at this same edge.
  // The order matters: the block may take the next number at the edge that
  // ends the final character of the previous one.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        if (expected_chars.size() == 0) begin
          note_mismatch($sformatf("unexpected character %0d, last_digit %0b",
                                  digit_char, last_digit));
        end else begin
          want_char = expected_chars.pop_front();
          if (digit_char !== want_char.ch || last_digit !== want_char.last) begin
            note_mismatch($sformatf("expected char %0d last %0b, got char %0d last %0b",
                                    want_char.ch, want_char.last, digit_char, last_digit));
          end
        end
      end
      if (start && !busy) begin
        predict_digits(number_value);
        accepted_count++;
      end
    end
  end

  initial begin
    logic [63:0]   pow_ten [MAX_DIGITS + 1];
    logic [63:0]   lo;
    logic [63:0]   hi;
    logic [31:0]   value;
    int unsigned   digits_wanted;
    int unsigned   pick;
    int unsigned   gap;

    pow_ten[0] = 64'd1;
    for (int i = 1; i <= MAX_DIGITS; i++) begin
      pow_ten[i] = pow_ten[i-1] * 64'd10;
    end

    // Directed numbers: zero, the edges of the 1/2, 2/3, 4/5 and 9/10 digit
    // counts, both halves of the sign bit, the largest values and alternating
    // bit patterns. A few carry gaps, and one waits for the output to drain.
    queue_number(32'd0, 0, 1'b0);
    queue_number(32'd1, 0, 1'b0);
    queue_number(32'd9, 0, 1'b0);
    queue_number(32'd10, 3, 1'b0);
    queue_number(32'd99, 0, 1'b0);
    queue_number(32'd100, 0, 1'b0);
    queue_number(32'd9999, 0, 1'b0);
    queue_number(32'd10000, 17, 1'b0);
    queue_number(32'd65535, 0, 1'b0);
    queue_number(32'd65536, 0, 1'b0);
    queue_number(32'd999999999, 0, 1'b0);
    queue_number(32'd1000000000, 0, 1'b0);
    queue_number(32'd1234567890, 40, 1'b0);
    queue_number(32'h7FFF_FFFF, 0, 1'b0);
    queue_number(32'h8000_0000, 0, 1'b0);
    queue_number(32'h8000_0001, 0, 1'b0);
    queue_number(32'hFFFF_FFFE, 0, 1'b0);
    queue_number(32'hFFFF_FFFF, 0, 1'b0);
    queue_number(32'h5555_5555, 1, 1'b0);
    queue_number(32'hAAAA_AAAA, 0, 1'b0);
    queue_number(32'd4000000009, 0, 1'b0);
    queue_number(32'd0, 0, 1'b1);
    queue_number(32'd7, 0, 1'b0);

    // Random numbers. Most pick a digit count first and then a value of that
    // length, so that short and long outputs are about equally common; the
    // rest are raw 32-bit words that exercise every input bit. One stretch
    // runs with no gaps at all, and every so often an item waits for the
    // output to drain completely.
    for (int i = 0; i < 430; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        value = $urandom();
      end else begin
        digits_wanted = $urandom_range(1, MAX_DIGITS);
        lo = (digits_wanted == 1) ? 64'd0 : pow_ten[digits_wanted-1];
        hi = pow_ten[digits_wanted] - 64'd1;
        if (hi > 64'hFFFF_FFFF) begin
          hi = 64'hFFFF_FFFF;
        end
        value = $urandom_range(hi[31:0], lo[31:0]);
      end
      pick = $urandom_range(0, 99);
      if (i >= 200 && i < 260) begin
        gap = 0;
      end else if (pick < 50) begin
        gap = 0;
      end else if (pick < 85) begin
        gap = $urandom_range(1, 4);
      end else if (pick < 95) begin
        gap = $urandom_range(5, 20);
      end else begin
        gap = $urandom_range(30, 90);
      end
      queue_number(value, gap, (i % 70) == 69);
    end

    // Reset is held at the start and released on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every number to be taken and every character to arrive, then
    // give the block a little longer to show any stray strobe.
    while (pending_numbers.size() != 0 || issued_count != accepted_count) begin
      @(posedge clk);
    end
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("PASS binary_to_decimal_ascii_emitter_top");
    end else begin
      $display("FAIL binary_to_decimal_ascii_emitter_top");
    end
    $finish;
  end

  // Watchdog. A correct run finishes well within this time, even with
  // every number at ten digits and every gap at its longest.
  initial begin
    #1000000;
    $display("FAIL binary_to_decimal_ascii_emitter_top");
    $finish;
  end

endmodule
`default_nettype wire
